[rtl/ipv4_rule_packet_filter_assert.svh]
// Assertion macros shared by the IPv4 rule packet filter RTL.
`ifndef IPV4_RULE_PACKET_FILTER_ASSERT_SVH
`define IPV4_RULE_PACKET_FILTER_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define IPV4F_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define IPV4F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ipv4f_pkg.sv]
// Types, constants and codes shared by the IPv4 rule packet filter modules.
`timescale 1ns / 1ps
package ipv4f_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_RULES     = 3;
  localparam int CFG_REG_COUNT = 2 * CFG_RULES;

  // Rule control register layout.
  localparam int CTL_W         = 10;
  localparam int CTL_PROTO_W   = 8;
  localparam int CTL_DROP_BIT  = 8;
  localparam int CTL_VALID_BIT = 9;
  localparam int ADDR_W        = 32;

  // Parameter defaults.
  localparam int RULE_COUNT_DEF  = 3;
  localparam int COUNT_WIDTH_DEF = 32;

  // Result field widths.
  localparam int TOTAL_W    = 32;
  localparam int RULE_IDX_W = 2;
  localparam logic [RULE_IDX_W-1:0] RULE_NONE = 2'd3;

  // Frame layout, in byte positions from the destination MAC.
  localparam int POS_W           = 16;
  localparam int POS_ETYPE_HI    = 12;
  localparam int POS_ETYPE_LO    = 13;
  localparam int POS_IHL         = 14;
  localparam int POS_PROTO       = 23;
  localparam int POS_SRC_FIRST   = 26;
  localparam int POS_DST_FIRST   = 30;
  localparam int POS_DST_LAST    = 33;
  localparam int MIN_FRAME_BYTES = 34;
  localparam int ETH_HDR_BYTES   = 14;
  localparam int MIN_IP_HDR_BYTES = 20;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_ABORT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       empty_frame;
  } in_item_t;

  typedef struct packed {
    verdict_t              verdict;
    logic [RULE_IDX_W-1:0] matched_rule;
    logic                  header_ok;
    logic [TOTAL_W-1:0]    processed_total;
    logic [TOTAL_W-1:0]    allowed_total;
    logic [TOTAL_W-1:0]    dropped_total;
    logic [TOTAL_W-1:0]    invalid_total;
  } out_item_t;

  // Outcome of the rule lookup for one header.
  typedef struct packed {
    logic                  hit;
    logic                  drop;
    logic [RULE_IDX_W-1:0] idx;
  } rule_hit_t;

endpackage

[rtl/ipv4f_rule_table.sv]
// Rule registers with their configuration write decode and the first-match lookup.
`timescale 1ns / 1ps
module ipv4f_rule_table #(
  parameter int RULE_COUNT = ipv4f_pkg::RULE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ipv4f_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipv4f_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [ipv4f_pkg::ADDR_W-1:0]      src_addr,
  input  logic [ipv4f_pkg::ADDR_W-1:0]      dst_addr,
  input  logic [7:0]                        ip_proto,
  output ipv4f_pkg::rule_hit_t              hit
);
  import ipv4f_pkg::*;

  // Rule slots past the register list never match and hold no storage.
  localparam int RULE_USED = (RULE_COUNT < CFG_RULES) ? RULE_COUNT : CFG_RULES;

  logic [CFG_DATA_W-1:0] addr_r [RULE_USED];
  logic [CTL_W-1:0]      ctl_r  [RULE_USED];
  logic                  idx_ok;

  assign idx_ok = (32'(cfg_index) < CFG_REG_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RULE_USED; i++) begin
        addr_r[i] <= '0;
        ctl_r[i]  <= '0;
      end
    end else if (cfg_we && idx_ok) begin
      for (int i = 0; i < RULE_USED; i++) begin
        if (cfg_index[CFG_INDEX_W-1:1] == (CFG_INDEX_W-1)'(i)) begin
          if (cfg_index[0]) begin
            ctl_r[i] <= cfg_data[CTL_W-1:0];
          end else begin
            addr_r[i] <= cfg_data;
          end
        end
      end
    end
  end

  // Walk from the last rule down so the lowest matching index wins.
  always_comb begin
    logic [ADDR_W-1:0]      rs;
    logic [ADDR_W-1:0]      rd;
    logic [CTL_PROTO_W-1:0] rp;
    hit.hit  = 1'b0;
    hit.drop = 1'b0;
    hit.idx  = RULE_NONE;
    for (int i = RULE_USED - 1; i >= 0; i--) begin
      rs = addr_r[i][CFG_DATA_W-1:ADDR_W];
      rd = addr_r[i][ADDR_W-1:0];
      rp = ctl_r[i][CTL_PROTO_W-1:0];
      if (ctl_r[i][CTL_VALID_BIT] &&
          (rs == '0 || rs == src_addr) &&
          (rd == '0 || rd == dst_addr) &&
          (rp == '0 || rp == ip_proto)) begin
        hit.hit  = 1'b1;
        hit.drop = ctl_r[i][CTL_DROP_BIT];
        hit.idx  = RULE_IDX_W'(i);
      end
    end
  end

endmodule

[rtl/ipv4_rule_packet_filter.sv]
// Top level of the IPv4 rule packet filter: header capture, verdict, counters, output buffer.
`timescale 1ns / 1ps
// The filter takes an Ethernet frame one byte per item, starting at the destination MAC,
// and returns one result item per frame: at the byte marked frame_end, or at an empty-frame
// mark, which discards any partial frame and reports an abort. While bytes stream in, the
// EtherType, the IHL nibble, the protocol and both IPv4 addresses are captured. At the last
// byte the header is checked (at least 34 bytes, EtherType 0x0800, IHL*4 of 20 or more and
// a header that fits in the frame); a usable header is then tried against the rules in index
// order, a zero field acting as a wildcard, and the first enabled rule that matches passes
// or drops the frame, while no match passes it. Four saturating counters are reported with
// every result, already including the frame just finished. One item is accepted every clock
// cycle while in_stall is low: the capture, the rule compare and the counter update for an
// item are combinational between the capture registers and the output register, so a result
// is registered as its final byte is taken. The result side is a two-entry buffer (output
// register plus skid register); in_stall rises only while both hold results that the
// consumer has not taken. Configuration writes are always ready and must be made while no
// frame is in progress.
module ipv4_rule_packet_filter #(
  parameter int RULE_COUNT  = ipv4f_pkg::RULE_COUNT_DEF,
  parameter int COUNT_WIDTH = ipv4f_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ipv4f_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ipv4f_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ipv4f_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipv4f_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ipv4f_pkg::*;

`include "ipv4_rule_packet_filter_assert.svh"

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Per-frame capture state.
  logic [POS_W-1:0]  pos_r;
  logic [15:0]       etype_r;
  logic [3:0]        ihl_r;
  logic [7:0]        proto_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] dst_r;

  // Values after taking in the current byte.
  logic [POS_W-1:0]  pos_nxt;
  logic [15:0]       etype_nxt;
  logic [3:0]        ihl_nxt;
  logic [7:0]        proto_nxt;
  logic [ADDR_W-1:0] src_nxt;
  logic [ADDR_W-1:0] dst_nxt;

  // Frame counters.
  logic [COUNT_WIDTH-1:0] processed_r, allowed_r, dropped_r, invalid_r;
  logic [COUNT_WIDTH-1:0] processed_nxt, allowed_nxt, dropped_nxt, invalid_nxt;

  // Output buffer.
  out_item_t out_data_r;
  out_item_t skid_data_r;
  logic      out_valid_r;
  logic      skid_valid_r;

  logic      in_accept;
  logic      out_pop;
  logic      push;
  logic      header_ok;
  logic [5:0] hdr_bytes;
  rule_hit_t  rule_hit;
  out_item_t  result;

  assign in_accept  = in_valid && !in_stall;
  assign out_pop    = out_valid_r && !out_stall;
  assign push       = in_accept && (in_data.empty_frame || in_data.frame_end);

  // The stall only depends on the skid register, so it is a clean registered signal.
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Header capture for the byte at the current position.
  always_comb begin
    etype_nxt = etype_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (pos_r == POS_W'(POS_ETYPE_HI) || pos_r == POS_W'(POS_ETYPE_LO)) begin
      etype_nxt = {etype_r[7:0], in_data.frame_byte};
    end else if (pos_r == POS_W'(POS_IHL)) begin
      ihl_nxt = 4'(in_data.frame_byte & IHL_MASK);
    end else if (pos_r == POS_W'(POS_PROTO)) begin
      proto_nxt = in_data.frame_byte;
    end else if (pos_r >= POS_W'(POS_SRC_FIRST) && pos_r < POS_W'(POS_DST_FIRST)) begin
      src_nxt = {src_r[ADDR_W-9:0], in_data.frame_byte};
    end else if (pos_r >= POS_W'(POS_DST_FIRST) && pos_r <= POS_W'(POS_DST_LAST)) begin
      dst_nxt = {dst_r[ADDR_W-9:0], in_data.frame_byte};
    end
    // The position saturates on very long frames, which cannot change any check.
    pos_nxt = pos_r + POS_W'(pos_r != '1);
  end

  // After the last byte, pos_nxt is the frame length.
  assign hdr_bytes = {ihl_nxt, 2'b00};
  assign header_ok = (pos_nxt >= POS_W'(MIN_FRAME_BYTES)) &&
                     (etype_nxt == ETHERTYPE_IPV4) &&
                     (hdr_bytes >= 6'(MIN_IP_HDR_BYTES)) &&
                     (POS_W'(ETH_HDR_BYTES) + POS_W'(hdr_bytes) <= pos_nxt);

  ipv4f_rule_table #(
    .RULE_COUNT (RULE_COUNT)
  ) u_rule_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_addr  (src_nxt),
    .dst_addr  (dst_nxt),
    .ip_proto  (proto_nxt),
    .hit       (rule_hit)
  );

  // Counter updates and the result item for this byte.
  always_comb begin
    processed_nxt = processed_r;
    allowed_nxt   = allowed_r;
    dropped_nxt   = dropped_r;
    invalid_nxt   = invalid_r;

    result.verdict      = VERDICT_PASS;
    result.matched_rule = RULE_NONE;
    result.header_ok    = 1'b0;

    if (in_data.empty_frame) begin
      invalid_nxt    = invalid_r + COUNT_WIDTH'(invalid_r != COUNT_MAX);
      result.verdict = VERDICT_ABORT;
    end else if (in_data.frame_end) begin
      processed_nxt = processed_r + COUNT_WIDTH'(processed_r != COUNT_MAX);
      if (!header_ok) begin
        invalid_nxt = invalid_r + COUNT_WIDTH'(invalid_r != COUNT_MAX);
      end else begin
        result.header_ok = 1'b1;
        if (rule_hit.hit) begin
          result.matched_rule = rule_hit.idx;
        end
        if (rule_hit.hit && rule_hit.drop) begin
          dropped_nxt    = dropped_r + COUNT_WIDTH'(dropped_r != COUNT_MAX);
          result.verdict = VERDICT_DROP;
        end else begin
          allowed_nxt = allowed_r + COUNT_WIDTH'(allowed_r != COUNT_MAX);
        end
      end
    end

    result.processed_total = TOTAL_W'(processed_nxt);
    result.allowed_total   = TOTAL_W'(allowed_nxt);
    result.dropped_total   = TOTAL_W'(dropped_nxt);
    result.invalid_total   = TOTAL_W'(invalid_nxt);
  end

  // Capture registers; a finished or aborted frame clears them for the next one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
    end else if (in_accept) begin
      if (in_data.empty_frame || in_data.frame_end) begin
        pos_r   <= '0;
        etype_r <= '0;
        ihl_r   <= '0;
        proto_r <= '0;
        src_r   <= '0;
        dst_r   <= '0;
      end else begin
        pos_r   <= pos_nxt;
        etype_r <= etype_nxt;
        ihl_r   <= ihl_nxt;
        proto_r <= proto_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      processed_r <= '0;
      allowed_r   <= '0;
      dropped_r   <= '0;
      invalid_r   <= '0;
    end else if (in_accept) begin
      processed_r <= processed_nxt;
      allowed_r   <= allowed_nxt;
      dropped_r   <= dropped_nxt;
      invalid_r   <= invalid_nxt;
    end
  end

  // Two-entry result buffer. The skid register only fills while the output register
  // holds a result that is not being taken, and it always drains first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || out_pop) begin
      if (push) begin
        out_data_r <= result;
      end
    end else if (push) begin
      skid_data_r <= result;
    end
  end

  `IPV4F_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid register holds a result while the output register is empty")

  `IPV4F_ASSERT_NEXT(a_frame_clears_pos, push, pos_r == '0,
    "byte position not cleared after a frame ended")

  `IPV4F_ASSERT_IMPL(a_drop_has_rule,
    out_valid_r && out_data_r.verdict == VERDICT_DROP,
    out_data_r.header_ok && out_data_r.matched_rule != RULE_NONE,
    "drop verdict without a parsed header and a matching rule")

  `IPV4F_ASSERT_IMPL(a_abort_clean,
    out_valid_r && out_data_r.verdict == VERDICT_ABORT,
    !out_data_r.header_ok && out_data_r.matched_rule == RULE_NONE,
    "aborted frame reports a header or a rule")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the IPv4 rule packet filter: directed and random frames.
`timescale 1ns / 1ps
module tb_top;
  import ipv4f_pkg::*;

  // Register map of the configuration port. Indexes past the last rule register are
  // accepted by the port but must leave the rule set untouched.
  localparam logic [CFG_INDEX_W-1:0] REG_RULE0_ADDR = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE0_CTL  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE1_ADDR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE1_CTL  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE2_ADDR = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE2_CTL  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE6     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE7     = 3'd7;

  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 4;

  // Block ports. Every input has a known value from time zero.
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ipv4_rule_packet_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mirror of the rule registers, updated as each write is accepted.
  logic [CFG_DATA_W-1:0] rule_addr [CFG_RULES] = '{default: '0};
  logic [CTL_W-1:0]      rule_ctl  [CFG_RULES] = '{default: '0};

  // Mirror of the header capture state and the four saturating counters.
  logic [POS_W-1:0]  cap_pos   = '0;
  logic [15:0]       cap_etype = '0;
  logic [3:0]        cap_ihl   = '0;
  logic [7:0]        cap_proto = '0;
  logic [ADDR_W-1:0] cap_src   = '0;
  logic [ADDR_W-1:0] cap_dst   = '0;
  logic [TOTAL_W-1:0] cnt_processed = '0;
  logic [TOTAL_W-1:0] cnt_allowed   = '0;
  logic [TOTAL_W-1:0] cnt_dropped   = '0;
  logic [TOTAL_W-1:0] cnt_invalid   = '0;

  // Verdicts predicted at input acceptance, oldest first.
  out_item_t verdict_q [$];

  // Bytes of the frame being built for transmission.
  logic [7:0] frame_buf [$];

  // Address and protocol pools shared by the random rules and random frames, so that
  // rules actually hit.
  logic [ADDR_W-1:0] addr_pool [4];
  logic [7:0]        proto_pool [3];

  int  error_count  = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  idle_cycles  = 0;
  int  rx_wait      = 0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_capture();
    cap_pos   = '0;
    cap_etype = '0;
    cap_ihl   = '0;
    cap_proto = '0;
    cap_src   = '0;
    cap_dst   = '0;
  endfunction

  // Captures the header fields by byte position. The position saturates on very long
  // frames, which is harmless since every field lies in the first 34 bytes.
  function automatic void capture_byte(input logic [7:0] b);
    if (cap_pos == POS_ETYPE_HI || cap_pos == POS_ETYPE_LO) begin
      cap_etype = {cap_etype[7:0], b};
    end else if (cap_pos == POS_IHL) begin
      cap_ihl = 4'(b & IHL_MASK);
    end else if (cap_pos == POS_PROTO) begin
      cap_proto = b;
    end else if (cap_pos >= POS_SRC_FIRST && cap_pos < POS_DST_FIRST) begin
      cap_src = {cap_src[ADDR_W-9:0], b};
    end else if (cap_pos >= POS_DST_FIRST && cap_pos <= POS_DST_LAST) begin
      cap_dst = {cap_dst[ADDR_W-9:0], b};
    end
    if (cap_pos != '1) begin
      cap_pos = cap_pos + 1'b1;
    end
  endfunction

  // Advances the mirror by one accepted item. Returns 1 with the expected result when the
  // item closes a frame or marks an empty one.
  function automatic bit filter_predict(input in_item_t it, output out_item_t res);
    int                hdr_bytes;
    bit                hit;
    logic [CTL_W-1:0]  ctl;
    logic [ADDR_W-1:0] rs;
    logic [ADDR_W-1:0] rd;
    logic [7:0]        rp;
    res = '0;
    res.verdict = VERDICT_PASS;
    res.matched_rule = RULE_NONE;
    hit = 1'b0;
    if (it.empty_frame) begin
      // An empty-frame mark throws away any partial frame, whatever frame_end says.
      clear_capture();
      cnt_invalid = sat_inc(cnt_invalid);
      res.verdict = VERDICT_ABORT;
    end else begin
      capture_byte(it.frame_byte);
      if (!it.frame_end) begin
        return 1'b0;
      end
      hdr_bytes = cap_ihl * 4;
      cnt_processed = sat_inc(cnt_processed);
      if (cap_pos < MIN_FRAME_BYTES || cap_etype != ETHERTYPE_IPV4 ||
          hdr_bytes < MIN_IP_HDR_BYTES || ETH_HDR_BYTES + hdr_bytes > cap_pos) begin
        cnt_invalid = sat_inc(cnt_invalid);
      end else begin
        res.header_ok = 1'b1;
        for (int r = 0; r < CFG_RULES && !hit; r++) begin
          ctl = rule_ctl[r];
          rs  = rule_addr[r][CFG_DATA_W-1:ADDR_W];
          rd  = rule_addr[r][ADDR_W-1:0];
          rp  = ctl[CTL_PROTO_W-1:0];
          if (ctl[CTL_VALID_BIT] && (rs == '0 || rs == cap_src) &&
              (rd == '0 || rd == cap_dst) && (rp == '0 || rp == cap_proto)) begin
            hit = 1'b1;
            res.matched_rule = RULE_IDX_W'(r);
            if (ctl[CTL_DROP_BIT]) begin
              res.verdict = VERDICT_DROP;
              cnt_dropped = sat_inc(cnt_dropped);
            end else begin
              cnt_allowed = sat_inc(cnt_allowed);
            end
          end
        end
        if (!hit) begin
          cnt_allowed = sat_inc(cnt_allowed);
        end
      end
      clear_capture();
    end
    res.processed_total = cnt_processed;
    res.allowed_total   = cnt_allowed;
    res.dropped_total   = cnt_dropped;
    res.invalid_total   = cnt_invalid;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                             input logic [TOTAL_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             results_seen, name, got, want));
    end
  endtask

  // Every result taken off the output is compared with the oldest prediction. After each
  // one the consumer draws how long it stalls before taking the next.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (verdict_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = verdict_q.pop_front();
        check_field("verdict", TOTAL_W'(out_data.verdict), TOTAL_W'(want.verdict));
        check_field("matched_rule", TOTAL_W'(out_data.matched_rule),
                    TOTAL_W'(want.matched_rule));
        check_field("header_ok", TOTAL_W'(out_data.header_ok), TOTAL_W'(want.header_ok));
        check_field("processed_total", out_data.processed_total, want.processed_total);
        check_field("allowed_total", out_data.allowed_total, want.allowed_total);
        check_field("dropped_total", out_data.dropped_total, want.dropped_total);
        check_field("invalid_total", out_data.invalid_total, want.invalid_total);
      end
    end
  end

  // The stall is changed only at the falling edge, so it is stable when sampled.
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall = 1'b1;
      rx_wait--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Ends a hung run: no handshake on any channel for too long means a lost result or a
  // stuck stall.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] ERROR: no handshake for %0d cycles, %0d results pending",
                 $realtime, idle_cycles, verdict_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------------------

  // Sends one item after a random gap. Valid is left high on return so that the next item
  // can follow back to back; whoever comes next either replaces the payload or drops valid
  // at the next falling edge.
  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t want;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (filter_predict(it, want)) begin
      verdict_q.push_back(want);
    end
  endtask

  // Stops sending and waits until every predicted result has been taken, then a few more
  // cycles so that nothing is left in flight inside the block.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one rule register. Only called while the block is drained.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_REG_COUNT) begin
      if (idx[0]) begin
        rule_ctl[idx >> 1] = value[CTL_W-1:0];
      end else begin
        rule_addr[idx >> 1] = value;
      end
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CTL_W-1:0] make_ctl(input bit valid, input bit drop,
                                                 input logic [7:0] proto);
    logic [CTL_W-1:0] c;
    c = '0;
    c[CTL_PROTO_W-1:0] = proto;
    c[CTL_DROP_BIT]    = drop;
    c[CTL_VALID_BIT]   = valid;
    return c;
  endfunction

  // Fills frame_buf with random bytes and plants the header fields that fall inside the
  // requested length. The IP version nibble is random since the block ignores it.
  task automatic make_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [ADDR_W-1:0] src,
                            input logic [ADDR_W-1:0] dst);
    logic [7:0] b;
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == POS_ETYPE_HI) begin
        b = etype[15:8];
      end else if (i == POS_ETYPE_LO) begin
        b = etype[7:0];
      end else if (i == POS_IHL) begin
        b = {4'($urandom), ihl};
      end else if (i == POS_PROTO) begin
        b = proto;
      end else if (i >= POS_SRC_FIRST && i < POS_DST_FIRST) begin
        b = src[8 * (POS_DST_FIRST - 1 - i) +: 8];
      end else if (i >= POS_DST_FIRST && i <= POS_DST_LAST) begin
        b = dst[8 * (POS_DST_LAST - i) +: 8];
      end
      frame_buf.push_back(b);
    end
  endtask

  // Sends frame_buf. An open frame leaves frame_end low on its last byte, so that an
  // empty-frame mark can cut it short.
  task automatic send_frame(input bit closed);
    in_item_t it;
    foreach (frame_buf[i]) begin
      it.frame_byte  = frame_buf[i];
      it.frame_end   = closed && (i == frame_buf.size() - 1);
      it.empty_frame = 1'b0;
      send_item(it);
    end
  endtask

  task automatic send_ipv4(input int len, input logic [3:0] ihl, input logic [7:0] proto,
                           input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst);
    make_frame(len, ETHERTYPE_IPV4, ihl, proto, src, dst);
    send_frame(1'b1);
  endtask

  task automatic send_empty(input bit end_flag);
    in_item_t it;
    it.frame_byte  = 8'($urandom_range(0, 255));
    it.frame_end   = end_flag;
    it.empty_frame = 1'b1;
    send_item(it);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // With all rules at their reset value, every usable frame passes with no rule matched.
  // Each way a header can be rejected is tried, plus the boundaries that are still legal.
  task automatic test_header_checks();
    send_ipv4(MIN_FRAME_BYTES, 4'd5, PROTO_TCP, $urandom, $urandom);
    send_ipv4(40, 4'd5, 8'h00, '0, '0);
    send_ipv4(40, 4'd5, 8'hFF, '1, '1);
    send_empty(1'b1);
    send_empty(1'b0);
    // A frame of a single byte, and one byte short of a full header.
    send_ipv4(1, 4'd5, PROTO_TCP, $urandom, $urandom);
    send_ipv4(MIN_FRAME_BYTES - 1, 4'd5, PROTO_TCP, $urandom, $urandom);
    make_frame(60, ETHERTYPE_IPV6, 4'd5, PROTO_UDP, $urandom, $urandom);
    send_frame(1'b1);
    // IHL below five words, including zero.
    send_ipv4(60, 4'd4, PROTO_UDP, $urandom, $urandom);
    send_ipv4(60, 4'd0, PROTO_UDP, $urandom, $urandom);
    // The largest IHL needs 74 bytes: one short runs past the end, exactly 74 fits.
    send_ipv4(73, 4'd15, PROTO_UDP, $urandom, $urandom);
    send_ipv4(74, 4'd15, PROTO_UDP, $urandom, $urandom);
    drain();
  endtask

  // Rule order, wildcards, drop against pass, the valid bit and the spare indexes.
  task automatic test_rule_match();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] c;
    a = 32'h0A00_0001;
    b = 32'hC0A8_0102;
    c = 32'h0808_0808;
    write_reg(REG_RULE0_ADDR, {a, b});
    write_reg(REG_RULE0_CTL, CFG_DATA_W'(make_ctl(1'b1, 1'b1, PROTO_TCP)));
    write_reg(REG_RULE1_ADDR, {a, 32'h0});
    write_reg(REG_RULE1_CTL, CFG_DATA_W'(make_ctl(1'b1, 1'b0, 8'h00)));
    write_reg(REG_RULE2_ADDR, '0);
    write_reg(REG_RULE2_CTL, CFG_DATA_W'(make_ctl(1'b1, 1'b1, PROTO_UDP)));
    // Writes past the last rule register must change nothing.
    write_reg(REG_SPARE6, '1);
    write_reg(REG_SPARE7, '1);
    send_ipv4(50, 4'd5, PROTO_TCP, a, b);
    send_ipv4(50, 4'd5, PROTO_UDP, a, b);
    send_ipv4(50, 4'd6, PROTO_TCP, a, c);
    send_ipv4(50, 4'd5, PROTO_UDP, c, b);
    send_ipv4(50, 4'd5, PROTO_TCP, c, b);
    drain();

    // Extremes: an all-ones rule, a disabled rule whose other control bits are all set, and a
    // rule that is wildcard in every field.
    write_reg(REG_RULE0_ADDR, '1);
    write_reg(REG_RULE0_CTL, '1);
    write_reg(REG_RULE1_ADDR, '0);
    write_reg(REG_RULE1_CTL, CFG_DATA_W'(make_ctl(1'b0, 1'b1, 8'hFF)));
    write_reg(REG_RULE2_CTL, CFG_DATA_W'(make_ctl(1'b1, 1'b0, 8'h00)));
    send_ipv4(60, 4'd5, 8'hFF, '1, '1);
    send_ipv4(60, 4'd5, 8'hFF, '1, c);
    send_ipv4(60, 4'd5, PROTO_ICMP, c, a);
    drain();
    write_reg(REG_RULE0_CTL, '0);
    write_reg(REG_RULE2_CTL, '0);
    send_ipv4(60, 4'd5, 8'hFF, '1, '1);
    drain();
  endtask

  // An empty-frame mark in the middle of a frame discards it; the next frame is parsed
  // from scratch.
  task automatic test_abort();
    write_reg(REG_RULE0_ADDR, '0);
    write_reg(REG_RULE0_CTL, CFG_DATA_W'(make_ctl(1'b1, 1'b1, PROTO_TCP)));
    make_frame(20, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, $urandom, $urandom);
    send_frame(1'b0);
    send_empty(1'b0);
    send_ipv4(40, 4'd5, PROTO_UDP, $urandom, $urandom);
    make_frame(40, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, $urandom, $urandom);
    send_frame(1'b0);
    send_empty(1'b1);
    send_ipv4(40, 4'd5, PROTO_TCP, $urandom, $urandom);
    drain();
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    return ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom) : addr_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] pick_proto();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : proto_pool[$urandom_range(0, 2)];
  endfunction

  // New pools, then a new rule set drawn mostly from them so that frames match often.
  task automatic randomize_rules();
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [7:0]        proto;
    foreach (addr_pool[i]) begin
      addr_pool[i] = ($urandom_range(0, 7) == 0) ? '1 : ADDR_W'($urandom);
    end
    proto_pool[0] = PROTO_TCP;
    proto_pool[1] = PROTO_UDP;
    proto_pool[2] = 8'($urandom_range(0, 255));
    for (int r = 0; r < CFG_RULES; r++) begin
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_RULE0_ADDR + CFG_INDEX_W'(2 * r), {$urandom, $urandom});
        write_reg(REG_RULE0_CTL + CFG_INDEX_W'(2 * r), CFG_DATA_W'($urandom_range(0, 1023)));
      end else begin
        src   = ($urandom_range(0, 2) == 0) ? '0 : addr_pool[$urandom_range(0, 3)];
        dst   = ($urandom_range(0, 2) == 0) ? '0 : addr_pool[$urandom_range(0, 3)];
        proto = ($urandom_range(0, 2) == 0) ? 8'h00 : proto_pool[$urandom_range(0, 2)];
        write_reg(REG_RULE0_ADDR + CFG_INDEX_W'(2 * r), {src, dst});
        write_reg(REG_RULE0_CTL + CFG_INDEX_W'(2 * r),
                  CFG_DATA_W'(make_ctl($urandom_range(0, 4) != 0,
                                       1'($urandom_range(0, 1)), proto)));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
    end
  endtask

  // Mostly well-formed IPv4 frames with random content, some rejected headers, and a
  // little noise: bare empty marks and frames cut short by one.
  task automatic random_frame();
    int kind;
    int len;
    int max_ihl;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(34, 200) : $urandom_range(34, 60);
      max_ihl = (len - ETH_HDR_BYTES) / 4;
      if (max_ihl > 15) begin
        max_ihl = 15;
      end
      send_ipv4(len, 4'($urandom_range(5, max_ihl)), pick_proto(), pick_addr(), pick_addr());
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: send_ipv4($urandom_range(1, MIN_FRAME_BYTES - 1), 4'd5, pick_proto(),
                     pick_addr(), pick_addr());
        1: begin
          make_frame($urandom_range(34, 60), 16'($urandom), 4'($urandom_range(5, 15)),
                     pick_proto(), pick_addr(), pick_addr());
          send_frame(1'b1);
        end
        2: send_ipv4($urandom_range(34, 60), 4'($urandom_range(0, 4)), pick_proto(),
                     pick_addr(), pick_addr());
        default: send_ipv4($urandom_range(34, 73), 4'd15, pick_proto(), pick_addr(),
                           pick_addr());
      endcase
    end else if (kind < 95) begin
      send_empty(1'($urandom_range(0, 1)));
    end else begin
      make_frame($urandom_range(1, 50), ETHERTYPE_IPV4, 4'd5, pick_proto(), pick_addr(),
                 pick_addr());
      send_frame(1'b0);
      send_empty(1'($urandom_range(0, 1)));
    end
  endtask

  // Phases of random frames, each under a fresh rule set written while the block is idle.
  // The idling of both sides changes now and then, leaving stretches at full rate.
  task automatic test_random();
    int start;
    int phase_start;
    start = items_sent;
    while (items_sent - start < 500) begin
      drain();
      randomize_rules();
      phase_start = items_sent;
      while (items_sent - phase_start < 100) begin
        if ($urandom_range(0, 7) == 0) begin
          tx_idle_on = $urandom_range(0, 2) != 0;
          rx_idle_on = $urandom_range(0, 2) != 0;
        end
        random_frame();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_header_checks();
    test_rule_match();
    test_abort();
    test_random();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[ipv4_rule_packet_filter.f]
+incdir+rtl
rtl/ipv4f_pkg.sv
rtl/ipv4f_rule_table.sv
rtl/ipv4_rule_packet_filter.sv
tb/tb_top.sv
